FILE: sv/hhsp_pkg.sv
`timescale 1ns / 1ps

package hhsp_pkg;

  typedef enum logic [3:0] {
    EvNone       = 4'd0,
    EvUriByte    = 4'd1,
    EvUriEnd     = 4'd2,
    EvNameByte   = 4'd3,
    EvNameEnd    = 4'd4,
    EvValueByte  = 4'd5,
    EvHeaderEnd  = 4'd6,
    EvLineDone   = 4'd7,
    EvStatusByte = 4'd8,
    EvHeadDone   = 4'd9,
    EvError      = 4'd10,
    EvIgnored    = 4'd11
  } event_e;

  localparam logic [2:0] MethodMax = 3'd6;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_message;
  } in_beat_t;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] data_out;
    logic [2:0] method_code;
    logic       version_minor;
  } out_beat_t;

endpackage

FILE: sv/hhsp_core.sv
`timescale 1ns / 1ps

module hhsp_core import hhsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      mode_i,
  input  in_beat_t  beat_i,
  output out_beat_t beat_o
);

  typedef enum logic [4:0] {
    StStart, StMethod, StSpUri, StUri, StUriHex1, StUriHex2, StUriQuery, StUriFrag,
    StSpVer, StVH, StVHt, StVHtt, StVHttp, StVSlash, StVOne, StVDot, StSpAfter,
    StLineCr, StHdrStart, StName, StSpValue, StValue, StHdrCr, StAllCr, StDone,
    StError, StStatus, StStatusCr
  } state_e;

  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChQuest = 8'h3f;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDel   = 8'h7f;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowH  = 8'h68;
  localparam logic [7:0] ChLowP  = 8'h70;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] CaseFold = 8'h20;

  // method names, seven characters, left aligned
  function automatic logic [55:0] meth_word(logic [2:0] m);
    logic [55:0] w;
    unique case (m)
      3'd0:    w = "GET    ";
      3'd1:    w = "HEAD   ";
      3'd2:    w = "POST   ";
      3'd3:    w = "OPTIONS";
      3'd4:    w = "DELETE ";
      3'd5:    w = "TRACE  ";
      3'd6:    w = "CONNECT";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] meth_len(logic [2:0] m);
    logic [2:0] n;
    unique case (m)
      3'd0:    n = 3'd3;
      3'd1:    n = 3'd4;
      3'd2:    n = 3'd4;
      3'd3:    n = 3'd7;
      3'd4:    n = 3'd6;
      3'd5:    n = 3'd5;
      3'd6:    n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] method_of(logic [7:0] c, output logic ok);
    logic [2:0] m;
    ok = 1'b1;
    unique case (c)
      "G":     m = 3'd0;
      "H":     m = 3'd1;
      "P":     m = 3'd2;
      "O":     m = 3'd3;
      "D":     m = 3'd4;
      "T":     m = 3'd5;
      "C":     m = 3'd6;
      default: begin
        m  = 3'd0;
        ok = 1'b0;
      end
    endcase
    return m;
  endfunction

  state_e     state_q, state_d;
  logic [2:0] meth_q, meth_d;
  logic [2:0] mpos_q, mpos_d;
  logic [3:0] hnib_q, hnib_d;
  logic       ver_q, ver_d;

  logic [7:0] c, f, mchar;
  logic [55:0] mword;
  logic [2:0] mfirst, cidx;
  logic       mok, is_ctl, is_letter, is_dig, is_af, bad;
  logic [3:0] hval;
  state_e     cur;
  event_e     ev;
  logic [7:0] data;

  always_comb begin
    c         = beat_i.byte_in;
    f         = c | CaseFold;
    is_ctl    = (c < ChSp) || (c == ChDel);
    is_letter = (f >= ChLowA) && (f <= ChLowZ);
    is_dig    = (c >= ChZero) && (c <= ChNine);
    is_af     = (f >= ChLowA) && (f <= ChLowF);
    hval      = is_dig ? c[3:0] : 4'(f - ChLowA + 8'd10);
    mfirst    = method_of(c, mok);

    // start_message clears everything before the byte is handled
    cur    = beat_i.start_message ? StStart : state_q;
    meth_d = beat_i.start_message ? 3'd0 : meth_q;
    mpos_d = beat_i.start_message ? 3'd0 : mpos_q;
    hnib_d = beat_i.start_message ? 4'd0 : hnib_q;
    ver_d  = beat_i.start_message ? 1'b0 : ver_q;

    mword   = meth_word(meth_d);
    cidx    = 3'(3'd6 - mpos_d);
    mchar   = mword[{cidx, 3'b000} +: 8];
    state_d = cur;
    ev      = EvNone;
    data    = 8'd0;
    bad     = 1'b0;

    unique case (cur)
      StStart: begin
        if (mode_i) begin
          if (c == ChCr) begin
            state_d = StStatusCr;
          end else begin
            state_d = StStatus;
            ev      = EvStatusByte;
            data    = c;
          end
        end else if (!mok) begin
          bad = 1'b1;
        end else begin
          meth_d  = mfirst;
          mpos_d  = 3'd1;
          state_d = StMethod;
        end
      end
      StMethod: begin
        if (meth_d > MethodMax) begin
          bad = 1'b1;
        end else if (mpos_d < meth_len(meth_d)) begin
          if (mchar == c) mpos_d = 3'(mpos_d + 3'd1);
          else bad = 1'b1;
        end else if (c == ChSp) begin
          state_d = StSpUri;
        end else begin
          bad = 1'b1;
        end
      end
      StSpUri: begin
        if (c == ChSlash) begin
          state_d = StUri;
          ev      = EvUriByte;
          data    = c;
        end else if (c != ChSp) begin
          bad = 1'b1;
        end
      end
      StUri, StUriHex1, StUriHex2, StUriQuery, StUriFrag: begin
        if (c == ChSp) begin
          if (cur == StUriHex1 || cur == StUriHex2) begin
            bad = 1'b1;
          end else begin
            state_d = StSpVer;
            ev      = EvUriEnd;
          end
        end else if (is_ctl) begin
          bad = 1'b1;
        end else if (cur == StUriFrag) begin
          ev = EvIgnored;
        end else if (cur == StUriHex1 || cur == StUriHex2) begin
          if (!(is_dig || is_af)) begin
            bad = 1'b1;
          end else if (cur == StUriHex1) begin
            hnib_d  = hval;
            state_d = StUriHex2;
          end else begin
            data    = {hnib_d, hval};
            ev      = EvUriByte;
            state_d = StUri;
          end
        end else if (c == ChHash) begin
          state_d = StUriFrag;
          ev      = EvIgnored;
        end else if (cur == StUri && c == ChPct) begin
          state_d = StUriHex1;
        end else begin
          if (cur == StUri && c == ChQuest) state_d = StUriQuery;
          ev   = EvUriByte;
          data = c;
        end
      end
      StSpVer: begin
        if (f == ChLowH) state_d = StVH;
        else if (c != ChSp) bad = 1'b1;
      end
      StVH: begin
        if (f == ChLowT) state_d = StVHt; else bad = 1'b1;
      end
      StVHt: begin
        if (f == ChLowT) state_d = StVHtt; else bad = 1'b1;
      end
      StVHtt: begin
        if (f == ChLowP) state_d = StVHttp; else bad = 1'b1;
      end
      StVHttp: begin
        if (c == ChSlash) state_d = StVSlash; else bad = 1'b1;
      end
      StVSlash: begin
        if (c == ChOne) state_d = StVOne; else bad = 1'b1;
      end
      StVOne: begin
        if (c == ChDot) state_d = StVDot; else bad = 1'b1;
      end
      StVDot: begin
        if (c == ChZero || c == ChOne) begin
          ver_d   = c[0];
          state_d = StSpAfter;
        end else begin
          bad = 1'b1;
        end
      end
      StSpAfter: begin
        if (c == ChCr) state_d = StLineCr;
        else if (c != ChSp) bad = 1'b1;
      end
      StLineCr, StStatusCr: begin
        if (c == ChLf) begin
          state_d = StHdrStart;
          ev      = EvLineDone;
        end else begin
          bad = 1'b1;
        end
      end
      StStatus: begin
        if (c == ChCr) begin
          state_d = StStatusCr;
        end else begin
          ev   = EvStatusByte;
          data = c;
        end
      end
      StHdrStart: begin
        if (c == ChCr) begin
          state_d = StAllCr;
        end else if (is_letter || c == ChDash) begin
          state_d = StName;
          ev      = EvNameByte;
          data    = c;
        end else begin
          bad = 1'b1;
        end
      end
      StName: begin
        if (is_letter || c == ChDash) begin
          ev   = EvNameByte;
          data = c;
        end else if (c == ChColon) begin
          state_d = StSpValue;
          ev      = EvNameEnd;
        end else begin
          bad = 1'b1;
        end
      end
      StSpValue: begin
        if (c == ChSp) begin
          ev = EvNone;
        end else if (!is_ctl) begin
          state_d = StValue;
          ev      = EvValueByte;
          data    = c;
        end else begin
          bad = 1'b1;
        end
      end
      StValue: begin
        if (c == ChCr) begin
          state_d = StHdrCr;
          ev      = EvHeaderEnd;
        end else if (!is_ctl) begin
          ev   = EvValueByte;
          data = c;
        end else begin
          bad = 1'b1;
        end
      end
      StHdrCr: begin
        if (c == ChLf) state_d = StHdrStart; else bad = 1'b1;
      end
      StAllCr: begin
        if (c == ChLf) begin
          state_d = StDone;
          ev      = EvHeadDone;
        end else begin
          bad = 1'b1;
        end
      end
      StDone: ev = EvIgnored;
      default: bad = 1'b1;
    endcase

    // sticky error, data forced to zero
    if (bad) begin
      state_d = StError;
      ev      = EvError;
      data    = 8'd0;
    end

    beat_o.event_res     = ev;
    beat_o.data_out      = data;
    beat_o.method_code   = meth_d;
    beat_o.version_minor = ver_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StStart;
      meth_q  <= 3'd0;
      mpos_q  <= 3'd0;
      hnib_q  <= 4'd0;
      ver_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      meth_q  <= meth_d;
      mpos_q  <= mpos_d;
      hnib_q  <= hnib_d;
      ver_q   <= ver_d;
    end
  end

endmodule

FILE: sv/http_header_stream_parser_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// in       input      in_valid_i/stall   in_beat_t  (byte_in, start_message)
// out      output     out_valid_o/stall  out_beat_t (event, data, method, version)
// cfg      input      cfg_valid_i/ready  parse_mode, one bit
//
// One byte per cycle sustained while the output does not stall; a byte passes
// through the input register, then the result register, before its result
// beat leaves.
// The parser state feeds back through one combinational step, which sets the rate.
// Reset clears the parser state and parse_mode; no clearing pass is needed.
// A stalled result holds in the output register while the next byte waits
// in the input register; in_stall_o rises only when both are full.
module http_header_stream_parser_unit import hhsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  in_beat_t  in_q;
  logic      in_valid_q;
  out_beat_t out_q, step_out;
  logic      out_valid_q;
  logic      mode_q;
  logic      advance;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  hhsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .mode_i (mode_q),
    .beat_i (in_q),
    .beat_o (step_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) mode_q <= cfg_data_i;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_data_i;
    if (advance) out_q <= step_out;
  end

endmodule

FILE: sv/hhsp_checker.sv
`timescale 1ns / 1ps

module hhsp_checker import hhsp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // an accepted byte reaches the output when the output is not stalled as it leaves the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted byte produced no result");

  // data only travels with byte events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res != EvUriByte && out_data_o.event_res != EvNameByte
      && out_data_o.event_res != EvValueByte && out_data_o.event_res != EvStatusByte
      |-> out_data_o.data_out == 8'd0)
    else $error("nonzero data on a non-byte event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.method_code <= MethodMax)
    else $error("method code out of range");

endmodule

bind http_header_stream_parser_unit hhsp_checker u_hhsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: sim/http_header_stream_parser_unit_test.sv
`timescale 1ns / 1ps

module http_header_stream_parser_unit_test;
  import hhsp_pkg::*;

  localparam logic [7:0] Cr = 8'h0d;
  localparam logic [7:0] Lf = 8'h0a;
  localparam logic [7:0] CaseFold = 8'h20;
  localparam logic [3:0] NoMethod = 4'd15;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 6;
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 200;

  typedef enum logic [4:0] {
    PsStart, PsMethod, PsSpUri, PsUri, PsUriHex1, PsUriHex2, PsUriQuery, PsUriFrag,
    PsSpVer, PsVH, PsVHt, PsVHtt, PsVHttp, PsVSlash, PsVOne, PsVDot, PsSpAfter,
    PsLineCr, PsHdrStart, PsName, PsSpValue, PsValue, PsHdrCr, PsAllCr, PsDone,
    PsError, PsStatus, PsStatusCr
  } parse_state_e;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;

  // predictor copy of the parser
  logic         pm_mode = 1'b0;
  parse_state_e pm_state = PsStart;
  logic [2:0]   pm_method = '0;
  logic [2:0]   pm_matched = '0;
  logic [3:0]   pm_nibble = '0;
  logic         pm_minor = 1'b0;

  out_beat_t  pending_events[$];
  stim_row_t  directed_rows[$];
  logic [7:0] msg_bytes[$];
  int         send_pct = 0;
  int         stall_pct = 0;
  int         sent_beats = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  http_header_stream_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_ctl(logic [7:0] c);
    return c < 8'd32 || c == 8'd127;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    logic [7:0] f;
    f = c | CaseFold;
    return f >= "a" && f <= "z";
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] f;
    f = c | CaseFold;
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (f >= "a" && f <= "f") return 5'(f - "a" + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [3:0] method_of(logic [7:0] c);
    case (c)
      "G": return 4'd0;
      "H": return 4'd1;
      "P": return 4'd2;
      "O": return 4'd3;
      "D": return 4'd4;
      "T": return 4'd5;
      "C": return 4'd6;
      default: return NoMethod;
    endcase
  endfunction

  function automatic string method_name(logic [2:0] m);
    case (m)
      3'd0: return "GET";
      3'd1: return "HEAD";
      3'd2: return "POST";
      3'd3: return "OPTIONS";
      3'd4: return "DELETE";
      3'd5: return "TRACE";
      3'd6: return "CONNECT";
      default: return "";
    endcase
  endfunction

  function automatic out_beat_t parse_byte_event(in_beat_t b);
    logic [7:0] c;
    event_e     ev;
    logic [7:0] data;
    bit         bad;
    logic [4:0] h;
    logic [3:0] m;
    string      name;
    out_beat_t  r;
    c = b.byte_in;
    ev = EvNone;
    data = 8'h00;
    bad = 1'b0;
    if (b.start_message) begin
      pm_state = PsStart;
      pm_method = '0;
      pm_matched = '0;
      pm_nibble = '0;
      pm_minor = 1'b0;
    end
    case (pm_state)
      PsStart: begin
        if (pm_mode) begin
          if (c == Cr) pm_state = PsStatusCr;
          else begin
            pm_state = PsStatus;
            ev = EvStatusByte;
            data = c;
          end
        end else begin
          m = method_of(c);
          if (m == NoMethod) bad = 1'b1;
          else begin
            pm_method = m[2:0];
            pm_matched = 3'd1;
            pm_state = PsMethod;
          end
        end
      end
      PsMethod: begin
        if (pm_method > MethodMax) bad = 1'b1;
        else begin
          name = method_name(pm_method);
          if (pm_matched < name.len()) begin
            if (name[pm_matched] == c) pm_matched = pm_matched + 3'd1;
            else bad = 1'b1;
          end else if (c == " ") pm_state = PsSpUri;
          else bad = 1'b1;
        end
      end
      PsSpUri: begin
        if (c == "/") begin
          pm_state = PsUri;
          ev = EvUriByte;
          data = c;
        end else if (c != " ") bad = 1'b1;
      end
      PsUri, PsUriHex1, PsUriHex2, PsUriQuery, PsUriFrag: begin
        if (c == " ") begin
          if (pm_state == PsUriHex1 || pm_state == PsUriHex2) bad = 1'b1;
          else begin
            pm_state = PsSpVer;
            ev = EvUriEnd;
          end
        end else if (is_ctl(c)) bad = 1'b1;
        else if (pm_state == PsUriFrag) ev = EvIgnored;
        else if (pm_state == PsUriHex1 || pm_state == PsUriHex2) begin
          h = hex_digit(c);
          if (h > 5'd15) bad = 1'b1;
          else if (pm_state == PsUriHex1) begin
            pm_nibble = h[3:0];
            pm_state = PsUriHex2;
          end else begin
            data = {pm_nibble, h[3:0]};
            ev = EvUriByte;
            pm_state = PsUri;
          end
        end else if (c == "#") begin
          pm_state = PsUriFrag;
          ev = EvIgnored;
        end else if (pm_state == PsUri && c == "%") pm_state = PsUriHex1;
        else begin
          // inside the query a percent sign passes through undecoded
          if (pm_state == PsUri && c == "?") pm_state = PsUriQuery;
          ev = EvUriByte;
          data = c;
        end
      end
      PsSpVer: begin
        if ((c | CaseFold) == "h") pm_state = PsVH;
        else if (c != " ") bad = 1'b1;
      end
      PsVH:     if ((c | CaseFold) == "t") pm_state = PsVHt; else bad = 1'b1;
      PsVHt:    if ((c | CaseFold) == "t") pm_state = PsVHtt; else bad = 1'b1;
      PsVHtt:   if ((c | CaseFold) == "p") pm_state = PsVHttp; else bad = 1'b1;
      PsVHttp:  if (c == "/") pm_state = PsVSlash; else bad = 1'b1;
      PsVSlash: if (c == "1") pm_state = PsVOne; else bad = 1'b1;
      PsVOne:   if (c == ".") pm_state = PsVDot; else bad = 1'b1;
      PsVDot: begin
        if (c == "0" || c == "1") begin
          pm_minor = c[0];
          pm_state = PsSpAfter;
        end else bad = 1'b1;
      end
      PsSpAfter: begin
        if (c == Cr) pm_state = PsLineCr;
        else if (c != " ") bad = 1'b1;
      end
      PsLineCr, PsStatusCr: begin
        if (c == Lf) begin
          pm_state = PsHdrStart;
          ev = EvLineDone;
        end else bad = 1'b1;
      end
      PsStatus: begin
        if (c == Cr) pm_state = PsStatusCr;
        else begin
          ev = EvStatusByte;
          data = c;
        end
      end
      PsHdrStart: begin
        if (c == Cr) pm_state = PsAllCr;
        else if (is_letter(c) || c == "-") begin
          pm_state = PsName;
          ev = EvNameByte;
          data = c;
        end else bad = 1'b1;
      end
      PsName: begin
        if (is_letter(c) || c == "-") begin
          ev = EvNameByte;
          data = c;
        end else if (c == ":") begin
          pm_state = PsSpValue;
          ev = EvNameEnd;
        end else bad = 1'b1;
      end
      PsSpValue: begin
        if (c == " ") ;
        else if (!is_ctl(c)) begin
          pm_state = PsValue;
          ev = EvValueByte;
          data = c;
        end else bad = 1'b1;
      end
      PsValue: begin
        if (c == Cr) begin
          pm_state = PsHdrCr;
          ev = EvHeaderEnd;
        end else if (!is_ctl(c)) begin
          ev = EvValueByte;
          data = c;
        end else bad = 1'b1;
      end
      PsHdrCr: if (c == Lf) pm_state = PsHdrStart; else bad = 1'b1;
      PsAllCr: begin
        if (c == Lf) begin
          pm_state = PsDone;
          ev = EvHeadDone;
        end else bad = 1'b1;
      end
      PsDone: ev = EvIgnored;
      default: bad = 1'b1;
    endcase
    if (bad) begin
      pm_state = PsError;
      ev = EvError;
      data = 8'h00;
    end
    r.event_res = ev;
    r.data_out = data;
    r.method_code = pm_method;
    r.version_minor = pm_minor;
    return r;
  endfunction

  function automatic logic [7:0] random_case(logic [7:0] c);
    if (is_letter(c) && $urandom_range(1) == 1) return c ^ CaseFold;
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (v < 4'd10) return "0" + 8'(v);
    return random_case("a" + 8'(v) - 8'd10);
  endfunction

  task automatic add_text(string s, bit mixed);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(mixed ? random_case(s[i]) : s[i]);
  endtask

  task automatic add_row(input logic [7:0] c, input bit restart, input bit typed = 1'b0,
                         input event_e ev = EvNone, input logic [7:0] d = 8'h00,
                         input logic [2:0] m = 3'd0, input logic v = 1'b0);
    stim_row_t row;
    row.beat.byte_in = c;
    row.beat.start_message = restart;
    row.typed = typed;
    row.want.event_res = ev;
    row.want.data_out = d;
    row.want.method_code = m;
    row.want.version_minor = v;
    directed_rows.push_back(row);
  endtask

  // mostly well-formed heads with random content, some noise and broken ones
  task automatic build_message(logic resp);
    int n;
    int k;
    logic [7:0] c;
    msg_bytes.delete();
    if ($urandom_range(99) < 7) begin
      n = $urandom_range(6, 1);
      repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    if (resp) begin
      n = $urandom_range(10);
      repeat (n) begin
        c = 8'($urandom_range(255));
        if (c == Cr) c = " ";
        msg_bytes.push_back(c);
      end
    end else begin
      add_text(method_name(3'($urandom_range(6))), 1'b0);
      repeat ($urandom_range(3, 1)) msg_bytes.push_back(" ");
      msg_bytes.push_back("/");
      n = $urandom_range(8);
      repeat (n) begin
        k = $urandom_range(99);
        if (k < 50) msg_bytes.push_back(8'($urandom_range(8'h7e, 8'h21)));
        else if (k < 65) begin
          msg_bytes.push_back("%");
          msg_bytes.push_back(hex_char());
          msg_bytes.push_back(($urandom_range(19) == 0) ? "g" : hex_char());
        end else if (k < 74) msg_bytes.push_back("?");
        else if (k < 80) msg_bytes.push_back("#");
        else if (k < 98) msg_bytes.push_back(8'($urandom_range(8'hff, 8'h80)));
        else msg_bytes.push_back(($urandom_range(1) == 1) ? 8'h7f : 8'($urandom_range(8'h1f)));
      end
      repeat ($urandom_range(2, 1)) msg_bytes.push_back(" ");
      add_text("HTTP", 1'b1);
      msg_bytes.push_back("/");
      msg_bytes.push_back(($urandom_range(49) == 0) ? "2" : "1");
      msg_bytes.push_back(".");
      if ($urandom_range(49) == 0) msg_bytes.push_back("9");
      else msg_bytes.push_back(($urandom_range(1) == 1) ? "1" : "0");
      repeat ($urandom_range(2)) msg_bytes.push_back(" ");
    end
    msg_bytes.push_back(Cr);
    msg_bytes.push_back(Lf);
    n = $urandom_range(3);
    repeat (n) begin
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(9) == 0) msg_bytes.push_back("-");
        else msg_bytes.push_back(random_case("a" + 8'($urandom_range(25))));
      end
      msg_bytes.push_back(":");
      repeat ($urandom_range(2)) msg_bytes.push_back(" ");
      k = ($urandom_range(49) == 0) ? 0 : $urandom_range(8, 1);
      repeat (k) begin
        if ($urandom_range(4) == 0) c = 8'($urandom_range(8'hff, 8'h80));
        else c = 8'($urandom_range(8'h7e, 8'h20));
        if ($urandom_range(99) == 0) c = 8'($urandom_range(8'h1f));
        msg_bytes.push_back(c);
      end
      msg_bytes.push_back(Cr);
      msg_bytes.push_back(Lf);
    end
    msg_bytes.push_back(Cr);
    msg_bytes.push_back(Lf);
    repeat ($urandom_range(2)) msg_bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(99) < 8)
      msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
  endtask

  // hold the beat until accepted, then advance the predictor
  task automatic drive_byte(input in_beat_t b, output out_beat_t predicted);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = parse_byte_event(b);
  endtask

  task automatic send_message(bit start_first, int count);
    in_beat_t  b;
    out_beat_t p;
    for (int i = 0; i < count; i++) begin
      b.byte_in = msg_bytes[i];
      b.start_message = (i == 0) ? start_first : ($urandom_range(199) == 0);
      drive_byte(b, p);
      pending_events.push_back(p);
      sent_beats++;
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pm_mode = v;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (out_data_o.event_res !== want.event_res) begin
          $display("%0t: event_res expected %0d, got %0d", $time, want.event_res,
                   out_data_o.event_res);
          mismatches++;
        end
        if (out_data_o.data_out !== want.data_out) begin
          $display("%0t: data_out expected %h, got %h", $time, want.data_out,
                   out_data_o.data_out);
          mismatches++;
        end
        if (out_data_o.method_code !== want.method_code) begin
          $display("%0t: method_code expected %0d, got %0d", $time, want.method_code,
                   out_data_o.method_code);
          mismatches++;
        end
        if (out_data_o.version_minor !== want.version_minor) begin
          $display("%0t: version_minor expected %0d, got %0d", $time, want.version_minor,
                   out_data_o.version_minor);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("** http_header_stream_parser_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    out_beat_t predicted;
    bit        first_msg;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // request head with escape, high byte, query, fragment; errors and trailing byte
    add_row(8'h00, 1'b1, 1'b1, EvError);
    add_row(8'hff, 1'b0, 1'b1, EvError);
    add_row("G", 1'b1, 1'b1, EvNone);
    add_row("E", 1'b0);
    add_row("T", 1'b0);
    add_row(" ", 1'b0);
    add_row("/", 1'b0, 1'b1, EvUriByte, "/");
    add_row("%", 1'b0);
    add_row("4", 1'b0);
    add_row("f", 1'b0);
    add_row(8'hff, 1'b0);
    add_row("?", 1'b0);
    add_row("%", 1'b0);
    add_row("#", 1'b0);
    add_row(" ", 1'b0);
    add_row("h", 1'b0);
    add_row("T", 1'b0);
    add_row("t", 1'b0);
    add_row("P", 1'b0);
    add_row("/", 1'b0);
    add_row("1", 1'b0);
    add_row(".", 1'b0);
    add_row("1", 1'b0);
    add_row(Cr, 1'b0);
    add_row(Lf, 1'b0);
    add_row(Cr, 1'b0);
    add_row(Lf, 1'b0, 1'b1, EvHeadDone, 8'h00, 3'd0, 1'b1);
    add_row(8'hff, 1'b0, 1'b1, EvIgnored, 8'h00, 3'd0, 1'b1);
    foreach (directed_rows[i]) begin
      drive_byte(directed_rows[i].beat, predicted);
      pending_events.push_back(directed_rows[i].typed ? directed_rows[i].want : predicted);
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      write_mode(1'((phase % 2) ^ (phase / 4)));
      case (phase % 4)
        0: begin
          send_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_pct = 59;
          stall_pct = 0;
        end
        2: begin
          send_pct = 0;
          stall_pct = 59;
        end
        default: begin
          send_pct = 24;
          stall_pct = 24;
        end
      endcase
      sent_beats = 0;
      first_msg = 1'b1;
      while (sent_beats < PhaseItems) begin
        build_message(pm_mode);
        // the first head may continue the unfinished one under the old mode
        if (first_msg) send_message(1'($urandom_range(1)), msg_bytes.size());
        else send_message($urandom_range(99) >= 5, msg_bytes.size());
        first_msg = 1'b0;
      end
      // leave a head unfinished so the next mode write lands mid-message
      build_message(pm_mode);
      send_message(1'b1, $urandom_range(msg_bytes.size() - 1));
    end

    drain_results();
    if (mismatches == 0) begin
      $display("** http_header_stream_parser_unit: PASSED **");
    end else begin
      $display("** http_header_stream_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: http_header_stream_parser_unit.f
sv/hhsp_pkg.sv
sv/hhsp_core.sv
sv/http_header_stream_parser_unit.sv
sv/hhsp_checker.sv
sim/http_header_stream_parser_unit_test.sv
